// ===== design/lsolve_pkg.sv =====
// ----------------------------------------------------------------------------
// lsolve_pkg
// Shared types and fixed widths of the 2x2 Cramer's rule solver.
// ----------------------------------------------------------------------------
package lsolve_pkg;

    // width of each solution field, fixed point
    localparam int OUT_W = 48;

    // control word handed from the front end to the divider stages
    typedef struct packed {
        logic valid;
        logic singular;
        logic neg_x;
        logic neg_y;
    } lsolve_ctl_t;

endpackage

// ===== design/lsolve_req_if.sv =====
// ----------------------------------------------------------------------------
// lsolve_req_if
// Request channel: one 2x2 system, six signed coefficients per word.
// ----------------------------------------------------------------------------
interface lsolve_req_if #(
    parameter int COEF_WIDTH = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [COEF_WIDTH-1:0] coef_x_first;
    logic signed [COEF_WIDTH-1:0] coef_y_first;
    logic signed [COEF_WIDTH-1:0] rhs_first;
    logic signed [COEF_WIDTH-1:0] coef_x_second;
    logic signed [COEF_WIDTH-1:0] coef_y_second;
    logic signed [COEF_WIDTH-1:0] rhs_second;

    modport source (
        output valid, coef_x_first, coef_y_first, rhs_first,
               coef_x_second, coef_y_second, rhs_second,
        input  ready
    );

    modport sink (
        input  valid, coef_x_first, coef_y_first, rhs_first,
               coef_x_second, coef_y_second, rhs_second,
        output ready
    );
endinterface

// ===== design/lsolve_res_if.sv =====
// ----------------------------------------------------------------------------
// lsolve_res_if
// Result channel: x and y in signed fixed point plus the singular flag.
// ----------------------------------------------------------------------------
interface lsolve_res_if
    import lsolve_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] x_value;
    logic signed [OUT_W-1:0] y_value;
    logic                    singular;

    modport source (
        output valid, x_value, y_value, singular,
        input  ready
    );

    modport sink (
        input  valid, x_value, y_value, singular,
        output ready
    );
endinterface

// ===== design/lsolve_front.sv =====
// ----------------------------------------------------------------------------
// lsolve_front
// Three-stage front end: products, determinant and numerators, then
// sign and magnitude for the divider lanes.
// ----------------------------------------------------------------------------
module lsolve_front
    import lsolve_pkg::*;
#(
    parameter int COEF_WIDTH = 16,
    parameter int MAG_W      = 2 * COEF_WIDTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic signed [COEF_WIDTH-1:0] a00,
    input  logic signed [COEF_WIDTH-1:0] a01,
    input  logic signed [COEF_WIDTH-1:0] b0,
    input  logic signed [COEF_WIDTH-1:0] a10,
    input  logic signed [COEF_WIDTH-1:0] a11,
    input  logic signed [COEF_WIDTH-1:0] b1,
    output lsolve_ctl_t                  ctl,
    output logic        [MAG_W-1:0]      det_mag,
    output logic        [MAG_W-1:0]      nx_mag,
    output logic        [MAG_W-1:0]      ny_mag
);

    localparam int PROD_W = 2 * COEF_WIDTH;
    localparam int DIFF_W = PROD_W + 1;

    // stage 1: the six products
    logic                     v1_reg;
    logic signed [PROD_W-1:0] p_reg [6];
    logic signed [PROD_W-1:0] p_next [6];

    // stage 2: exact differences
    logic                     v2_reg;
    logic signed [DIFF_W-1:0] det_reg, nx_reg, ny_reg;
    logic signed [DIFF_W-1:0] det_next, nx_next, ny_next;

    // stage 3: sign and magnitude
    lsolve_ctl_t              ctl_reg, ctl_next;
    logic        [MAG_W-1:0]  det_mag_reg, nx_mag_reg, ny_mag_reg;
    logic        [DIFF_W-1:0] det_abs, nx_abs, ny_abs;

    always_comb
    begin
        p_next[0] = PROD_W'(a00 * a11);
        p_next[1] = PROD_W'(a01 * a10);
        p_next[2] = PROD_W'(a11 * b0);
        p_next[3] = PROD_W'(a01 * b1);
        p_next[4] = PROD_W'(a00 * b1);
        p_next[5] = PROD_W'(a10 * b0);
    end

    always_comb
    begin
        det_next = DIFF_W'(p_reg[0]) - DIFF_W'(p_reg[1]);
        nx_next  = DIFF_W'(p_reg[2]) - DIFF_W'(p_reg[3]);
        ny_next  = DIFF_W'(p_reg[4]) - DIFF_W'(p_reg[5]);
    end

    always_comb
    begin
        det_abs = det_reg[DIFF_W-1] ? DIFF_W'(-det_reg) : DIFF_W'(det_reg);
        nx_abs  = nx_reg[DIFF_W-1]  ? DIFF_W'(-nx_reg)  : DIFF_W'(nx_reg);
        ny_abs  = ny_reg[DIFF_W-1]  ? DIFF_W'(-ny_reg)  : DIFF_W'(ny_reg);

        ctl_next.valid    = v2_reg;
        ctl_next.singular = (det_reg == '0);
        // a zero numerator gives a plain zero, never a negated one
        ctl_next.neg_x    = (nx_reg[DIFF_W-1] ^ det_reg[DIFF_W-1]) && (nx_reg != '0);
        ctl_next.neg_y    = (ny_reg[DIFF_W-1] ^ det_reg[DIFF_W-1]) && (ny_reg != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            ctl_reg <= '0;
        end
        else if (en)
        begin
            v1_reg  <= in_valid;
            v2_reg  <= v1_reg;
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg       <= p_next;
            det_reg     <= det_next;
            nx_reg      <= nx_next;
            ny_reg      <= ny_next;
            det_mag_reg <= det_abs[MAG_W-1:0];
            nx_mag_reg  <= nx_abs[MAG_W-1:0];
            ny_mag_reg  <= ny_abs[MAG_W-1:0];
        end
    end

    assign ctl     = ctl_reg;
    assign det_mag = det_mag_reg;
    assign nx_mag  = nx_mag_reg;
    assign ny_mag  = ny_mag_reg;

endmodule

// ===== design/lsolve_div.sv =====
// ----------------------------------------------------------------------------
// lsolve_div
// Pipelined restoring divider: one quotient bit per stage, DIV_W stages.
// Computes (num_mag << FRAC_BITS) / den_mag truncated, carries the sign.
// ----------------------------------------------------------------------------
module lsolve_div #(
    parameter int MAG_W     = 32,
    parameter int FRAC_BITS = 16,
    parameter int DIV_W     = MAG_W + FRAC_BITS
) (
    input  logic             clk,
    input  logic             en,
    input  logic [MAG_W-1:0] num_mag,
    input  logic [MAG_W-1:0] den_mag,
    input  logic             neg_in,
    output logic [DIV_W-1:0] quot,
    output logic             neg_out
);

    logic [MAG_W-1:0] rem_reg [DIV_W];
    logic [DIV_W-1:0] dq_reg  [DIV_W];
    logic [MAG_W-1:0] den_reg [DIV_W];
    logic             neg_reg [DIV_W];

    for (genvar s = 0; s < DIV_W; s++)
    begin : g_stage
        logic [MAG_W-1:0] rem_prev;
        logic [DIV_W-1:0] dq_prev;
        logic [MAG_W-1:0] den_prev;
        logic             neg_prev;
        logic [MAG_W:0]   shifted;
        logic [MAG_W:0]   trial;
        logic [MAG_W-1:0] rem_next;
        logic [DIV_W-1:0] dq_next;

        if (s == 0)
        begin : g_first
            assign rem_prev = '0;
            assign dq_prev  = DIV_W'(num_mag) << FRAC_BITS;
            assign den_prev = den_mag;
            assign neg_prev = neg_in;
        end
        else
        begin : g_rest
            assign rem_prev = rem_reg[s-1];
            assign dq_prev  = dq_reg[s-1];
            assign den_prev = den_reg[s-1];
            assign neg_prev = neg_reg[s-1];
        end

        // shift in the next dividend bit, keep the trial difference if nonnegative
        always_comb
        begin
            shifted = {rem_prev, dq_prev[DIV_W-1]};
            trial   = shifted - {1'b0, den_prev};
            if (!trial[MAG_W])
            begin
                rem_next = trial[MAG_W-1:0];
                dq_next  = {dq_prev[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[MAG_W-1:0];
                dq_next  = {dq_prev[DIV_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s] <= rem_next;
                dq_reg[s]  <= dq_next;
                den_reg[s] <= den_prev;
                neg_reg[s] <= neg_prev;
            end
        end
    end

    assign quot    = dq_reg[DIV_W-1];
    assign neg_out = neg_reg[DIV_W-1];

endmodule

// ===== design/two_by_two_linear_solver.sv =====
// ----------------------------------------------------------------------------
// two_by_two_linear_solver
// Cramer's rule solver for a 2x2 integer system, fixed-point quotients.
// ----------------------------------------------------------------------------
// One system is accepted per clock and one result word leaves per clock
// while no result word waits untaken at the output. A request passes
// through three front-end stages for the products, the determinant and
// numerators and their magnitudes, one stage per quotient bit in each of
// the two restoring divider lanes, and the output register that negates
// and saturates. When the result is not taken, the whole pipeline holds;
// request ready drops only while a result waits at the output. A zero
// determinant gives singular = 1 with x_value and y_value at zero;
// otherwise each value is truncated toward zero and saturated to the
// signed 48-bit range.
// ----------------------------------------------------------------------------
module two_by_two_linear_solver
    import lsolve_pkg::*;
#(
    parameter int COEF_WIDTH = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    lsolve_req_if.sink           request,
    lsolve_res_if.source         result
);

    localparam int MAG_W = 2 * COEF_WIDTH;
    localparam int DIV_W = MAG_W + FRAC_BITS;
    localparam int EXT_W = (DIV_W > OUT_W) ? DIV_W : OUT_W;
    localparam logic [EXT_W-1:0] POS_LIMIT = (EXT_W'(1) << (OUT_W - 1)) - EXT_W'(1);
    localparam logic [EXT_W-1:0] NEG_LIMIT = EXT_W'(1) << (OUT_W - 1);

    logic             en;
    lsolve_ctl_t      ctl;
    logic [MAG_W-1:0] det_mag, nx_mag, ny_mag;
    logic [DIV_W-1:0] qx, qy;
    logic             neg_x, neg_y;

    logic             vld_reg [DIV_W];
    logic             sng_reg [DIV_W];

    logic             out_valid_reg;
    logic [OUT_W-1:0] x_reg, y_reg, x_next, y_next;
    logic             sing_reg;

    // advance everything unless a finished word is still waiting
    assign en            = !out_valid_reg || result.ready;
    assign request.ready = en;

    lsolve_front #(
        .COEF_WIDTH (COEF_WIDTH),
        .MAG_W      (MAG_W)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (request.valid),
        .a00      (request.coef_x_first),
        .a01      (request.coef_y_first),
        .b0       (request.rhs_first),
        .a10      (request.coef_x_second),
        .a11      (request.coef_y_second),
        .b1       (request.rhs_second),
        .ctl      (ctl),
        .det_mag  (det_mag),
        .nx_mag   (nx_mag),
        .ny_mag   (ny_mag)
    );

    lsolve_div #(
        .MAG_W     (MAG_W),
        .FRAC_BITS (FRAC_BITS),
        .DIV_W     (DIV_W)
    ) u_div_x (
        .clk     (clk),
        .en      (en),
        .num_mag (nx_mag),
        .den_mag (det_mag),
        .neg_in  (ctl.neg_x),
        .quot    (qx),
        .neg_out (neg_x)
    );

    lsolve_div #(
        .MAG_W     (MAG_W),
        .FRAC_BITS (FRAC_BITS),
        .DIV_W     (DIV_W)
    ) u_div_y (
        .clk     (clk),
        .en      (en),
        .num_mag (ny_mag),
        .den_mag (det_mag),
        .neg_in  (ctl.neg_y),
        .quot    (qy),
        .neg_out (neg_y)
    );

    // valid and singular ride alongside the divider stages
    for (genvar s = 0; s < DIV_W; s++)
    begin : g_side
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[s] <= (s == 0) ? ctl.valid : vld_reg[(s == 0) ? 0 : s - 1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sng_reg[s] <= (s == 0) ? ctl.singular : sng_reg[(s == 0) ? 0 : s - 1];
            end
        end
    end

    // clamp to the limit of the sign, then negate
    function automatic logic [OUT_W-1:0] sat_value(
        input logic [DIV_W-1:0] q,
        input logic             neg
    );
        logic [EXT_W-1:0] q_ext;
        logic [EXT_W-1:0] limit;
        logic [EXT_W-1:0] mag;
        q_ext = EXT_W'(q);
        limit = neg ? NEG_LIMIT : POS_LIMIT;
        mag   = (q_ext > limit) ? limit : q_ext;
        mag   = neg ? EXT_W'(-mag) : mag;
        return mag[OUT_W-1:0];
    endfunction

    always_comb
    begin
        if (sng_reg[DIV_W-1])
        begin
            x_next = '0;
            y_next = '0;
        end
        else
        begin
            x_next = sat_value(qx, neg_x);
            y_next = sat_value(qy, neg_y);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= vld_reg[DIV_W-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            sing_reg <= sng_reg[DIV_W-1];
        end
    end

    assign result.valid    = out_valid_reg;
    assign result.x_value  = x_reg;
    assign result.y_value  = y_reg;
    assign result.singular = sing_reg;

    // a singular word always carries zero solutions
    a_singular_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        (result.valid && result.singular) |-> (result.x_value == '0 && result.y_value == '0)
    ) else $error("singular result with nonzero solution");

    // a stalled output freezes the last divider stage
    a_stall_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        (result.valid && !result.ready) |=> ($stable(vld_reg[DIV_W-1])
                                             && $stable(sng_reg[DIV_W-1]))
    ) else $error("pipeline moved during an output stall");

    // request backpressure only comes from a waiting result word
    a_ready_cause: assert property (
        @(posedge clk) disable iff (!rst_n)
        !request.ready |-> (result.valid && !result.ready)
    ) else $error("request stalled without a waiting result");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 2x2 Cramer's rule solver.
// Feeds coefficient words (corner systems, then random traffic under varying
// sender and receiver stalls), predicts x, y and the singular flag in fixed
// point for every accepted word, and compares each result word in order.
// ----------------------------------------------------------------------------
module testbench
    import lsolve_pkg::*;
;

    localparam int COEF_W     = 16;
    localparam int FRAC_W     = 16;
    localparam int LATENCY    = 2 * COEF_W + FRAC_W + 4;
    localparam int DRAIN_WAIT = 40000;
    localparam longint SAT_POS = (longint'(1) <<< (OUT_W - 1)) - 1;
    localparam longint SAT_NEG = -(longint'(1) <<< (OUT_W - 1));

    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic signed [OUT_W-1:0]  fixed_t;

    typedef struct {
        coef_t ax1;
        coef_t ay1;
        coef_t rhs1;
        coef_t ax2;
        coef_t ay2;
        coef_t rhs2;
    } system_t;

    typedef struct {
        fixed_t x;
        fixed_t y;
        logic   singular;
    } solution_t;

    logic clk;
    logic rst_n;

    lsolve_req_if #(.COEF_WIDTH(COEF_W)) req_ch ();
    lsolve_res_if                        res_ch ();

    two_by_two_linear_solver #(
        .COEF_WIDTH (COEF_W),
        .FRAC_BITS  (FRAC_W)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (req_ch),
        .result  (res_ch)
    );

    solution_t pending_solutions[$];
    int        fault_count   = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    logic      hold_rx       = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #2_400_000;
        $display("CHECK FAILED");
        $finish;
    end

    // (num * 2^FRAC) / den, truncated toward zero, clamped to the output range
    function automatic fixed_t fixed_quotient(longint num, longint den);
        longint q;
        q = (num * (longint'(1) <<< FRAC_W)) / den;
        if (q > SAT_POS)
            q = SAT_POS;
        else if (q < SAT_NEG)
            q = SAT_NEG;
        return fixed_t'(q);
    endfunction

    function automatic solution_t solve_cramer(system_t s);
        longint a, b, c, d, e, f, det;
        solution_t r;
        a = s.ax1;
        b = s.ay1;
        e = s.rhs1;
        c = s.ax2;
        d = s.ay2;
        f = s.rhs2;
        det = a * d - b * c;
        if (det == 0)
        begin
            r.x = '0;
            r.y = '0;
            r.singular = 1'b1;
        end
        else
        begin
            r.x = fixed_quotient(d * e - b * f, det);
            r.y = fixed_quotient(a * f - c * e, det);
            r.singular = 1'b0;
        end
        return r;
    endfunction

    function automatic system_t make_system(int ax1, int ay1, int rhs1,
                                            int ax2, int ay2, int rhs2);
        system_t s;
        s.ax1  = coef_t'(ax1);
        s.ay1  = coef_t'(ay1);
        s.rhs1 = coef_t'(rhs1);
        s.ax2  = coef_t'(ax2);
        s.ay2  = coef_t'(ay2);
        s.rhs2 = coef_t'(rhs2);
        return s;
    endfunction

    function automatic int corner_coef();
        case ($urandom_range(5))
            0: return -32768;
            1: return -32767;
            2: return -1;
            3: return 0;
            4: return 1;
            default: return 32767;
        endcase
    endfunction

    function automatic int narrow_coef();
        int v;
        v = $urandom_range(15);
        return v - 8;
    endfunction

    function automatic system_t random_system();
        system_t s;
        int      kind, bx, by, k;
        kind = $urandom_range(9);
        if (kind < 7)
        begin
            s = make_system($urandom(), $urandom(), $urandom(),
                            $urandom(), $urandom(), $urandom());
        end
        else if (kind == 7)
        begin
            // second row a multiple of the first: no unique solution
            bx = $urandom_range(32766);
            by = $urandom_range(32766);
            k  = $urandom_range(4);
            bx -= 16383;
            by -= 16383;
            k  -= 2;
            s = make_system(bx, by, $urandom(), bx * k, by * k, $urandom());
        end
        else if (kind == 8)
        begin
            s = make_system(narrow_coef(), narrow_coef(), narrow_coef(),
                            narrow_coef(), narrow_coef(), narrow_coef());
        end
        else
        begin
            s = make_system(corner_coef(), corner_coef(), corner_coef(),
                            corner_coef(), corner_coef(), corner_coef());
        end
        return s;
    endfunction

    task automatic report_fault(string what, longint want, longint got);
        if (fault_count < 10)
            $display("mismatch at %0t: %s expected %0d, got %0d", $realtime, what, want, got);
        fault_count++;
    endtask

    // Word to the solver: optional idle gap, then hold valid until taken.
    task automatic send_system(system_t s);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.coef_x_first  <= s.ax1;
        req_ch.coef_y_first  <= s.ay1;
        req_ch.rhs_first     <= s.rhs1;
        req_ch.coef_x_second <= s.ax2;
        req_ch.coef_y_second <= s.ay2;
        req_ch.rhs_second    <= s.rhs2;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    task automatic wait_results_drained();
        int waited;
        waited = 0;
        while (pending_solutions.size() != 0 && waited < DRAIN_WAIT)
        begin
            @(posedge clk);
            waited++;
        end
    endtask

    // Receiver: random stalls, or a forced hold-off when asked.
    always @(posedge clk)
    begin
        if (hold_rx || !rst_n)
            res_ch.ready <= 1'b0;
        else
            res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Predict on every accepted request, compare every accepted result.
    always @(posedge clk)
    begin
        system_t   s;
        solution_t want;
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                s.ax1  = req_ch.coef_x_first;
                s.ay1  = req_ch.coef_y_first;
                s.rhs1 = req_ch.rhs_first;
                s.ax2  = req_ch.coef_x_second;
                s.ay2  = req_ch.coef_y_second;
                s.rhs2 = req_ch.rhs_second;
                pending_solutions.push_back(solve_cramer(s));
            end
            if (res_ch.valid && res_ch.ready)
            begin
                if (pending_solutions.size() == 0)
                begin
                    report_fault("unexpected result word, x_value", 0, res_ch.x_value);
                end
                else
                begin
                    want = pending_solutions.pop_front();
                    if (res_ch.x_value !== want.x)
                        report_fault("x_value", want.x, res_ch.x_value);
                    if (res_ch.y_value !== want.y)
                        report_fault("y_value", want.y, res_ch.y_value);
                    if (res_ch.singular !== want.singular)
                        report_fault("singular", want.singular, res_ch.singular);
                end
            end
        end
    end

    task automatic test_corner_systems();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        // singular: all zero, all most negative, all most positive
        send_system(make_system(0, 0, 0, 0, 0, 0));
        send_system(make_system(-32768, -32768, -32768, -32768, -32768, -32768));
        send_system(make_system(32767, 32767, 32767, 32767, 32767, 32767));
        // proportional rows, inconsistent right-hand side
        send_system(make_system(2, -4, 6, -1, 2, 9));
        // first row zero
        send_system(make_system(0, 0, 5, 3, 4, 7));
        // identity and negated identity with extreme right-hand sides
        send_system(make_system(1, 0, 32767, 0, 1, -32768));
        send_system(make_system(-1, 0, -32768, 0, -1, 32767));
        // determinant -1 with the largest numerators
        send_system(make_system(32767, 32766, -32768, 32766, 32765, 32767));
        send_system(make_system(32767, 32766, 32767, 32766, 32765, -32768));
        send_system(make_system(-32768, -32767, -32768, -32767, -32766, 32767));
        // truncation toward zero on both signs
        send_system(make_system(3, 0, -1, 0, 3, 2));
        send_system(make_system(-7, 0, 10, 0, 1, -5));
        send_system(make_system(-3, 1, 1, 1, 3, -1));
        // zero numerators, nonzero determinant
        send_system(make_system(5, 3, 0, 2, 7, 0));
        send_system(make_system(-5, 3, 0, 2, 7, 0));
        // largest determinants of each sign
        send_system(make_system(-32768, 32767, 32767, -32768, -32768, -32768));
        send_system(make_system(-32768, 32767, -32768, 32767, 32767, 32767));
        send_system(make_system(32767, -32768, 1, -32768, -32768, -1));
        send_system(make_system(1, 1, 1, 1, -1, -1));
    endtask

    task automatic test_random_systems(int tx_idle, int rx_idle, int count);
        send_idle_pct = tx_idle;
        recv_idle_pct = rx_idle;
        repeat (count)
            send_system(random_system());
    endtask

    // Hold the result side long enough that the pipeline fills and the
    // request side stalls, while words keep being offered.
    task automatic test_output_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        fork
            begin
                hold_rx <= 1'b1;
                repeat (4 * LATENCY)
                    @(posedge clk);
                hold_rx <= 1'b0;
            end
            begin
                repeat (3 * LATENCY)
                    send_system(random_system());
            end
        join
    endtask

    task automatic test_pause_until_drained();
        send_idle_pct = 10;
        recv_idle_pct = 10;
        repeat (30)
            send_system(random_system());
        req_ch.valid <= 1'b0;
        @(posedge clk);
        wait_results_drained();
        repeat (30)
            send_system(random_system());
    endtask

    initial
    begin
        rst_n                <= 1'b0;
        req_ch.valid         <= 1'b0;
        req_ch.coef_x_first  <= '0;
        req_ch.coef_y_first  <= '0;
        req_ch.rhs_first     <= '0;
        req_ch.coef_x_second <= '0;
        req_ch.coef_y_second <= '0;
        req_ch.rhs_second    <= '0;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_corner_systems();
        test_random_systems(21, 70, 260);
        test_random_systems(70, 21, 260);
        test_random_systems(0, 0, 260);
        test_output_backpressure();
        test_pause_until_drained();

        req_ch.valid <= 1'b0;
        wait_results_drained();
        repeat (2 * LATENCY)
            @(posedge clk);
        if (pending_solutions.size() != 0)
        begin
            $display("%0d results never delivered", pending_solutions.size());
            fault_count += pending_solutions.size();
        end

        if (fault_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
